[rtl/mmn_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, codes and types for the min-max normalizer.
// No dependencies; every other file imports this package.
package mmn_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int QUO_W  = DATA_W + FRAC_W;
   localparam int CNT_W  = $clog2(QUO_W);
   localparam int IDX_W  = 2;
   localparam int STAT_W = 2;

   localparam logic signed [DATA_W-1:0] Q_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] ONE_Q   = DATA_W'(1) <<< FRAC_W;

   typedef enum logic [IDX_W-1:0] {
      CSR_USE_GIVEN = 2'd0,
      CSR_GIVEN_MIN = 2'd1,
      CSR_GIVEN_MAX = 2'd2
   } csr_idx_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ZERO_RANGE = 2'd1,
      STATUS_NO_RANGE   = 2'd2
   } status_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] min;
      logic signed [DATA_W-1:0] max;
   } range_type;

endpackage

[rtl/mmn_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and register write.
// Depends on mmn_pkg for field widths.
interface mmn_req_if;
   import mmn_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic                     first;
   logic signed [DATA_W-1:0] sample;
   modport source (output valid, mode, first, sample, input ready);
   modport sink   (input valid, mode, first, sample, output ready);
endinterface

interface mmn_rsp_if;
   import mmn_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] scaled;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] range_min;
   logic signed [DATA_W-1:0] range_max;
   modport source (output valid, scaled, status, range_min, range_max, input ready);
   modport sink   (input valid, scaled, status, range_min, range_max, output ready);
endinterface

interface mmn_csr_if;
   import mmn_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mmn_range.sv]
`timescale 1ns / 1ps
// Running minimum and maximum tracker for measure requests.
// Depends on mmn_pkg.
module mmn_range
   import mmn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     update,
   input  logic                     first,
   input  logic signed [DATA_W-1:0] sample,
   output range_type                range
);

   range_type range_ff, range_in;

   always_comb begin
      range_in = range_ff;
      if (update) begin
         range_in.valid = 1'b1;
         if (first || !range_ff.valid) begin
            range_in.min = sample;
            range_in.max = sample;
         end else begin
            if (sample < range_ff.min) range_in.min = sample;
            if (sample > range_ff.max) range_in.max = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= '0;
      end else begin
         range_ff <= range_in;
      end
   end

   assign range = range_ff;

endmodule

[rtl/mmn_div.sv]
`timescale 1ns / 1ps
// Fixed-point divider: (x - lo) * 2^16 / (hi - lo), one quotient bit per cycle,
// truncated toward zero and saturated to signed Q16.16. Depends on mmn_pkg.
module mmn_div
   import mmn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] x,
   input  logic signed [DATA_W-1:0] lo,
   input  logic signed [DATA_W-1:0] hi,
   input  logic                     ack,
   output logic                     busy,
   output logic                     done,
   output logic signed [DATA_W-1:0] quotient
);

   typedef enum logic [2:0] {
      D_IDLE, D_MAG, D_RUN, D_SAT, D_DONE
   } div_state_type;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

   div_state_type            state_ff, state_in;
   logic signed [DATA_W:0]   num_ff, num_in;
   logic signed [DATA_W:0]   den_ff, den_in;
   logic                     neg_ff, neg_in;
   logic [QUO_W-1:0]         shift_ff, shift_in;
   logic [DATA_W-1:0]        dmag_ff, dmag_in;
   logic [DATA_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [DATA_W-1:0] quo_ff, quo_in;

   logic [DATA_W:0] num_abs, den_abs, trial;
   logic            ge, over_pos, over_neg;

   always_comb begin
      num_abs  = num_ff[DATA_W] ? (DATA_W+1)'(-num_ff) : num_ff;
      den_abs  = den_ff[DATA_W] ? (DATA_W+1)'(-den_ff) : den_ff;
      trial    = {rem_ff, shift_ff[QUO_W-1]};
      ge       = trial >= {1'b0, dmag_ff};
      over_pos = |shift_ff[QUO_W-1:DATA_W-1];
      over_neg = (|shift_ff[QUO_W-1:DATA_W]) ||
                 (shift_ff[DATA_W-1] && (|shift_ff[DATA_W-2:0]));

      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      shift_in = shift_ff;
      dmag_in  = dmag_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;

      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               num_in   = {x[DATA_W-1], x} - {lo[DATA_W-1], lo};
               den_in   = {hi[DATA_W-1], hi} - {lo[DATA_W-1], lo};
               state_in = D_MAG;
            end
         end
         D_MAG: begin
            neg_in   = num_ff[DATA_W] ^ den_ff[DATA_W];
            shift_in = {num_abs[DATA_W-1:0], {FRAC_W{1'b0}}};
            dmag_in  = den_abs[DATA_W-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = D_RUN;
         end
         D_RUN: begin
            rem_in   = ge ? DATA_W'(trial - {1'b0, dmag_ff}) : trial[DATA_W-1:0];
            shift_in = {shift_ff[QUO_W-2:0], ge};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) state_in = D_SAT;
         end
         D_SAT: begin
            if (neg_ff) begin
               quo_in = over_neg ? Q_MIN : DATA_W'(-shift_ff[DATA_W-1:0]);
            end else begin
               quo_in = over_pos ? Q_MAX : shift_ff[DATA_W-1:0];
            end
            state_in = D_DONE;
         end
         D_DONE: begin
            if (ack) state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff   <= num_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      shift_ff <= shift_in;
      dmag_ff  <= dmag_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      quo_ff   <= quo_in;
   end

   assign busy     = state_ff != D_IDLE;
   assign done     = state_ff == D_DONE;
   assign quotient = quo_ff;

endmodule

[rtl/min_max_normalizer.sv]
`timescale 1ns / 1ps
// Min-max scaling of one signed Q16.16 column; uses mmn_pkg, mmn_if, mmn_range, mmn_div.
// Measure requests (mode 0) are accepted whenever the block is idle and update the
// running min and max; a scale request (mode 1) occupies the block through setup,
// the restoring divider that produces one of 48 quotient bits per cycle, saturation
// and response load; a scale request with a zero or unmeasured range skips the
// divider. One request is in flight at a time; a finished response waits in an output
// register. The user must write registers (given_min, given_max, use_given_range) only
// while idle; the block does not enforce this. The write port is always ready.
module min_max_normalizer
   import mmn_pkg::*;
(
   input logic        clock,
   input logic        reset,
   mmn_req_if.sink    req_ch,
   mmn_rsp_if.source  rsp_ch,
   mmn_csr_if.sink    csr_ch
);

   typedef enum logic {
      S_IDLE, S_BUSY
   } state_type;

   state_type                state_ff, state_in;
   logic                     use_given_ff;
   logic signed [DATA_W-1:0] given_min_ff, given_max_ff;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_scaled_ff, rsp_scaled_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_min_ff, rsp_min_in, rsp_max_ff, rsp_max_in;

   range_type                range;
   logic                     accept, measure, scale, finish, load;
   logic signed [DATA_W-1:0] sel_lo, sel_hi, div_q;
   status_type               status_now;
   logic                     div_start, div_busy, div_done;

   assign req_ch.ready = state_ff == S_IDLE;
   assign accept       = req_ch.valid && req_ch.ready;
   assign measure      = accept && !req_ch.mode;
   assign scale        = accept && req_ch.mode;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_given_ff <= 1'b0;
         given_min_ff <= '0;
         given_max_ff <= ONE_Q;
      end else if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_USE_GIVEN: use_given_ff <= csr_ch.data[0];
            CSR_GIVEN_MIN: given_min_ff <= csr_ch.data;
            CSR_GIVEN_MAX: given_max_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   mmn_range u_range (
      .clock  (clock),
      .reset  (reset),
      .update (measure),
      .first  (req_ch.first),
      .sample (req_ch.sample),
      .range  (range)
   );

   always_comb begin
      sel_lo = use_given_ff ? given_min_ff : range.min;
      sel_hi = use_given_ff ? given_max_ff : range.max;
      priority if (!use_given_ff && !range.valid) begin
         status_now = STATUS_NO_RANGE;
      end else if (sel_hi == sel_lo) begin
         status_now = STATUS_ZERO_RANGE;
      end else begin
         status_now = STATUS_OK;
      end
   end

   assign div_start = scale && (status_now == STATUS_OK);

   mmn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .x        (req_ch.sample),
      .lo       (sel_lo),
      .hi       (sel_hi),
      .ack      (load),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   assign finish = (state_ff == S_BUSY) && ((status_ff != STATUS_OK) || div_done);
   assign load   = finish && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_status_in = rsp_status_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (scale) begin
               status_in = status_now;
               lo_in     = sel_lo;
               hi_in     = sel_hi;
               state_in  = S_BUSY;
            end
         end
         S_BUSY: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_scaled_in = (status_ff == STATUS_OK) ? div_q : '0;
               rsp_status_in = status_ff;
               rsp_min_in    = lo_ff;
               rsp_max_in    = hi_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_status_ff <= rsp_status_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.scaled    = rsp_scaled_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.range_min = rsp_min_ff;
   assign rsp_ch.range_max = rsp_max_ff;

`ifndef ASSERT_OFF
   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !div_busy)
      else $error("request accepted while divider busy");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != STATUS_OK)) |-> (rsp_ch.scaled == '0))
      else $error("nonzero scaled value with error status");

   a_measure_silent: assert property (@(posedge clock) disable iff (reset)
      (measure && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("measure request produced a response");

   a_measure_valid: assert property (@(posedge clock) disable iff (reset)
      measure |=> range.valid)
      else $error("range not valid after measure request");
`endif

endmodule
